// ===== hw/rtl/bfc_pkg.sv =====
`default_nettype none

package bfc_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  localparam int COORD_W    = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_REGS   = 8;
  localparam int OUTCODE_W  = 6;

  // outcode bit positions
  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_BOTTOM = 2;
  localparam int OC_TOP    = 3;
  localparam int OC_NEAR   = 4;
  localparam int OC_FAR    = 5;

  typedef logic signed [COORD_W-1:0]     coord_t;
  typedef logic signed [2*COORD_W-1:0]   prod_t;
  typedef logic signed [2*COORD_W+1:0]   sum_t;   // four products
  typedef logic signed [2*COORD_W+2:0]   cmp_t;   // sum plus/minus w
  typedef logic [OUTCODE_W-1:0]          outcode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/box_frustum_cull.sv =====
// Throughput: one box per cycle unless a result stall backs up the pipeline;
// 24 parallel 32x32 multipliers (one per matrix entry and box bound) feed a
// corner-sum stage and a clip-compare stage.
// Reset (rst, synchronous): empties the pipeline and loads the identity matrix.
`default_nettype none

module box_frustum_cull import bfc_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  input  wire                    box_valid,
  output logic                   box_stall,
  input  wire signed [COORD_W-1:0] box_min_x,
  input  wire signed [COORD_W-1:0] box_min_y,
  input  wire signed [COORD_W-1:0] box_min_z,
  input  wire signed [COORD_W-1:0] box_max_x,
  input  wire signed [COORD_W-1:0] box_max_y,
  input  wire signed [COORD_W-1:0] box_max_z,
  output logic                   result_valid,
  input  wire                    result_stall,
  output logic [OUTCODE_W-1:0]   shared_outcode,
  output logic                   trivially_outside
);

  localparam coord_t ONE = coord_t'(64'sd1 <<< COORD_FRAC_BITS);

  coord_t mat [4][4];

  // pipeline registers
  logic   v0, v1, v2, v3;
  coord_t b_lo [3];
  coord_t b_hi [3];
  prod_t  p_lo [4][3];
  prod_t  p_hi [4][3];
  prod_t  wterm [4];
  sum_t   csum [8][4];

  prod_t    p_lo_next [4][3];
  prod_t    p_hi_next [4][3];
  prod_t    wterm_next [4];
  sum_t     csum_next [8][4];
  outcode_t outcode_next;

  logic ld0, ld1, ld2, ld3;

  assign ld3 = !v3 || !result_stall;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign ld0 = !v0 || ld1;
  assign box_stall    = !ld0;
  assign result_valid = v3;

  // matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 4; k++) begin
          mat[r][k] <= (r == k) ? ONE : '0;
        end
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(CFG_REGS))) begin
      mat[cfg_index[2:1]][{cfg_index[0], 1'b0}] <= cfg_data[COORD_W-1:0];
      mat[cfg_index[2:1]][{cfg_index[0], 1'b1}] <= cfg_data[CFG_DATA_W-1:COORD_W];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld0) v0 <= box_valid;
      if (ld1) v1 <= v0;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
    end
  end

  // products: each corner coordinate is either the min or the max bound,
  // so per row and axis only two products exist
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 3; k++) begin
        p_lo_next[r][k] = mat[r][k] * b_lo[k];
        p_hi_next[r][k] = mat[r][k] * b_hi[k];
      end
      wterm_next[r] = prod_t'(mat[r][3]) <<< COORD_FRAC_BITS;
    end
  end

  // corner n takes the max bound of axis i when bit i of n is set
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      for (int r = 0; r < 4; r++) begin
        csum_next[n][r] = sum_t'(wterm[r])
                        + sum_t'(n[0] ? p_hi[r][0] : p_lo[r][0])
                        + sum_t'(n[1] ? p_hi[r][1] : p_lo[r][1])
                        + sum_t'(n[2] ? p_hi[r][2] : p_lo[r][2]);
      end
    end
  end

  always_comb begin
    cmp_t     xp, xm, yp, ym, zm;
    outcode_t code;
    outcode_next = '1;
    for (int n = 0; n < 8; n++) begin
      xp = cmp_t'(csum[n][0]) + cmp_t'(csum[n][3]);
      xm = cmp_t'(csum[n][0]) - cmp_t'(csum[n][3]);
      yp = cmp_t'(csum[n][1]) + cmp_t'(csum[n][3]);
      ym = cmp_t'(csum[n][1]) - cmp_t'(csum[n][3]);
      zm = cmp_t'(csum[n][2]) - cmp_t'(csum[n][3]);
      code            = '0;
      code[OC_LEFT]   = xp[$bits(cmp_t)-1];
      code[OC_RIGHT]  = !xm[$bits(cmp_t)-1] && (|xm);
      code[OC_BOTTOM] = yp[$bits(cmp_t)-1];
      code[OC_TOP]    = !ym[$bits(cmp_t)-1] && (|ym);
      code[OC_NEAR]   = csum[n][2][$bits(sum_t)-1];
      code[OC_FAR]    = !zm[$bits(cmp_t)-1] && (|zm);
      outcode_next    = outcode_next & code;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ld0) begin
      b_lo[0] <= box_min_x;
      b_lo[1] <= box_min_y;
      b_lo[2] <= box_min_z;
      b_hi[0] <= box_max_x;
      b_hi[1] <= box_max_y;
      b_hi[2] <= box_max_z;
    end
    if (ld1) begin
      p_lo  <= p_lo_next;
      p_hi  <= p_hi_next;
      wterm <= wterm_next;
    end
    if (ld2) begin
      csum <= csum_next;
    end
    if (ld3) begin
      shared_outcode    <= outcode_next;
      trivially_outside <= |outcode_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfc_checker.sv =====
`default_nettype none

module bfc_checker import bfc_pkg::*; (
  input wire                 clk,
  input wire                 rst,
  input wire                 result_valid,
  input wire                 result_stall,
  input wire [OUTCODE_W-1:0] shared_outcode,
  input wire                 trivially_outside
);

  // cull flag must agree with the shared code on every beat
  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (trivially_outside == (shared_outcode != '0)))
    else $error("trivially_outside disagrees with shared_outcode");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result_valid high after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(shared_outcode) && $stable(trivially_outside))
    else $error("stalled result changed");

endmodule

bind box_frustum_cull bfc_checker u_bfc_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bfc_pkg::*;

  localparam int FRAC_BITS   = COORD_FRAC_BITS_DEF;
  localparam int Q           = 1 << FRAC_BITS;
  localparam int LATENCY     = 3;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;

  typedef logic signed [71:0] wide_t;
  typedef logic [CFG_DATA_W-1:0] reg_bank_t [CFG_REGS];

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    outcode_t code;
    logic     culled;
  } cull_result_t;

  class cull_scoreboard;
    coord_t mtx[4][4];
    cull_result_t expected[$];
    int errors;
    int checked;
    int culled_count;

    function new();
      errors = 0;
      checked = 0;
      culled_count = 0;
      for (int r = 0; r < 4; r++)
        for (int k = 0; k < 4; k++)
          mtx[r][k] = (r == k) ? coord_t'(Q) : '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      int row;
      int col;
      if (idx >= CFG_REGS) return;
      row = int'(idx >> 1);
      col = int'(idx[0]) * 2;
      mtx[row][col]     = data[31:0];
      mtx[row][col + 1] = data[63:32];
    endfunction

    function outcode_t corner_code(coord_t x, coord_t y, coord_t z);
      wide_t v[4];
      wide_t c[4];
      wide_t s;
      outcode_t code;
      v[0] = wide_t'(x);
      v[1] = wide_t'(y);
      v[2] = wide_t'(z);
      v[3] = wide_t'(Q);
      for (int r = 0; r < 4; r++) begin
        c[r] = '0;
        for (int k = 0; k < 4; k++)
          c[r] = c[r] + wide_t'(mtx[r][k]) * v[k];
      end
      code = '0;
      s = c[0] + c[3];  code[OC_LEFT]   = (s < 0);
      s = c[0] - c[3];  code[OC_RIGHT]  = (s > 0);
      s = c[1] + c[3];  code[OC_BOTTOM] = (s < 0);
      s = c[1] - c[3];  code[OC_TOP]    = (s > 0);
      s = c[2];         code[OC_NEAR]   = (s < 0);
      s = c[2] - c[3];  code[OC_FAR]    = (s > 0);
      return code;
    endfunction

    function void note_box(box_t b);
      outcode_t acc;
      cull_result_t res;
      acc = '1;
      // corner n picks the max bound on axis i when bit i of n is set
      for (int n = 0; n < 8; n++)
        acc &= corner_code(n[0] ? b.max_x : b.min_x,
                           n[1] ? b.max_y : b.min_y,
                           n[2] ? b.max_z : b.min_z);
      res.code = acc;
      res.culled = (acc != 0);
      expected.push_back(res);
    endfunction

    function void check_result(outcode_t code, logic culled);
      cull_result_t want;
      if (expected.size() == 0) begin
        $display("%0t: unexpected result beat: outcode %b trivially_outside %b",
                 $time, code, culled);
        errors++;
        return;
      end
      want = expected.pop_front();
      checked++;
      if (want.culled) culled_count++;
      if (code !== want.code) begin
        $display("%0t: shared_outcode expected %b actual %b", $time, want.code, code);
        errors++;
      end
      if (culled !== want.culled) begin
        $display("%0t: trivially_outside expected %b actual %b", $time, want.culled, culled);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void check_drained();
      if (expected.size() != 0) begin
        $display("%0t: %0d results expected but never seen", $time, expected.size());
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic box_valid = 1'b0;
  logic box_stall;
  coord_t box_min_x = '0;
  coord_t box_min_y = '0;
  coord_t box_min_z = '0;
  coord_t box_max_x = '0;
  coord_t box_max_y = '0;
  coord_t box_max_z = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  outcode_t shared_outcode;
  logic trivially_outside;

  cull_scoreboard sb = new();
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;
  int calm_left = 0;
  int boxes_sent = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  box_frustum_cull #(.COORD_FRAC_BITS(FRAC_BITS)) dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst || cfg_we || (box_valid && !box_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: checks every beat and stalls in random bursts
  initial begin : result_sink
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall)
        sb.check_result(shared_outcode, trivially_outside);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
        run_left = 0;
      end
      if (no_idle) stall_left = 0;
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else if (run_left > 0 || no_idle) begin
        result_stall <= 1'b0;
        if (run_left > 0) run_left--;
      end else begin
        result_stall <= 1'b0;
        if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 16);
        else run_left = $urandom_range(1, 40);
      end
    end
  end

  function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_t b;
    b.min_x = x0;
    b.min_y = y0;
    b.min_z = z0;
    b.max_x = x1;
    b.max_y = y1;
    b.max_z = z1;
    return b;
  endfunction

  function automatic box_t random_box();
    box_t b;
    int sel;
    int c[3];
    int e[3];
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      c[i] = int'($urandom_range(0, 16 * Q)) - 8 * Q;
      e[i] = (sel == 2) ? 0 : int'($urandom_range(0, 2 * Q));
    end
    if (sel < 2) begin
      b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if ($urandom_range(0, 7) == 0) begin
      // bounds handed over in swapped order
      b = make_box(c[0] + e[0], c[1] + e[1], c[2] + e[2], c[0], c[1], c[2]);
    end else begin
      b = make_box(c[0], c[1], c[2], c[0] + e[0], c[1] + e[1], c[2] + e[2]);
    end
    return b;
  endfunction

  function automatic reg_bank_t random_bank(bit narrow);
    reg_bank_t bank;
    int lo;
    int hi;
    for (int k = 0; k < CFG_REGS; k++) begin
      if (narrow) begin
        lo = int'($urandom_range(0, 4 * Q)) - 2 * Q;
        hi = int'($urandom_range(0, 4 * Q)) - 2 * Q;
      end else begin
        lo = $urandom;
        hi = $urandom;
      end
      bank[k] = {hi[31:0], lo[31:0]};
    end
    return bank;
  endfunction

  function automatic reg_bank_t uniform_bank(coord_t entry);
    reg_bank_t bank;
    for (int k = 0; k < CFG_REGS; k++)
      bank[k] = {entry, entry};
    return bank;
  endfunction

  // all tasks below are entered right after a rising edge
  task automatic send_box(box_t b);
    box_valid <= 1'b1;
    box_min_x <= b.min_x;
    box_min_y <= b.min_y;
    box_min_z <= b.min_z;
    box_max_x <= b.max_x;
    box_max_y <= b.max_y;
    box_max_z <= b.max_z;
    do @(posedge clk); while (box_stall);
    sb.note_box(b);
    boxes_sent++;
  endtask

  task automatic pace_sender();
    int gap;
    if (no_idle) return;
    if (calm_left > 0) begin
      calm_left--;
      return;
    end
    if ($urandom_range(0, 30) == 0) begin
      calm_left = $urandom_range(10, 40);
      return;
    end
    if ($urandom_range(0, 3) != 0) return;
    gap = $urandom_range(1, 16);
    box_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic run_boxes(int count);
    for (int i = 0; i < count; i++) begin
      send_box(random_box());
      pace_sender();
    end
  endtask

  task automatic drain();
    box_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic load_matrix(reg_bank_t bank);
    logic [CFG_IDX_W-1:0] junk_idx;
    logic [CFG_DATA_W-1:0] junk_data;
    for (int k = 0; k < CFG_REGS; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data <= bank[k];
      @(posedge clk);
      sb.write_reg(CFG_IDX_W'(k), bank[k]);
    end
    // index past the last register must leave the matrix alone
    junk_idx = CFG_IDX_W'(CFG_REGS + $urandom_range(0, (1 << CFG_IDX_W) - CFG_REGS - 1));
    junk_data = {$urandom, $urandom};
    cfg_index <= junk_idx;
    cfg_data <= junk_data;
    @(posedge clk);
    sb.write_reg(junk_idx, junk_data);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  initial begin : stimulus
    reg_bank_t bank;
    int lo;
    int hi;
    lo = 32'h8000_0000;
    hi = 32'h7fff_ffff;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity matrix after reset: w is 1.0, so each plane sits at +-1.0 or 0
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-5 * Q, 0, 0, -3 * Q, Q / 2, Q / 2));
    send_box(make_box(3 * Q, 0, 0, 5 * Q, Q / 2, Q / 2));
    send_box(make_box(0, -5 * Q, 0, Q / 2, -3 * Q, Q / 2));
    send_box(make_box(0, 3 * Q, 0, Q / 2, 5 * Q, Q / 2));
    send_box(make_box(0, 0, -2 * Q, Q / 2, Q / 2, -Q));
    send_box(make_box(0, 0, 2 * Q, Q / 2, Q / 2, 3 * Q));
    send_box(make_box(-5 * Q, 3 * Q, -2 * Q, -3 * Q, 5 * Q, -Q));
    send_box(make_box(lo, lo, lo, hi, hi, hi));
    send_box(make_box(hi, hi, hi, lo, lo, lo));
    send_box(make_box(lo, lo, lo, lo, lo, lo));
    send_box(make_box(hi, hi, hi, hi, hi, hi));
    send_box(make_box(5 * Q, 0, 0, 3 * Q, 0, 0));
    send_box(make_box(Q, Q, Q, Q, Q, Q));
    send_box(make_box(-Q, -Q, 0, -Q, -Q, 0));
    send_box(make_box(Q + 1, Q + 1, Q + 1, Q + 1, Q + 1, Q + 1));
    send_box(make_box(-Q - 1, -Q - 1, -1, -Q - 1, -Q - 1, -1));
    send_box(make_box(-5 * Q, -5 * Q, -5 * Q, 5 * Q, 5 * Q, 5 * Q));
    send_box(make_box(lo, 0, 0, -Q - 1, 0, 0));
    run_boxes(60);
    drain();

    // simple perspective: w = z, near plane at z = 1; receiver holds off here
    bank = uniform_bank('0);
    bank[0] = {32'd0, coord_t'(Q)};
    bank[1] = {32'd0, coord_t'(Q / 4)};
    bank[2] = {coord_t'(Q), 32'd0};
    bank[3] = {32'd0, coord_t'(Q / 4)};
    bank[5] = {coord_t'(-Q), coord_t'(Q)};
    bank[7] = {32'd0, coord_t'(Q)};
    load_matrix(bank);
    calm_left = 70;
    hold_req = 1'b1;
    run_boxes(70);
    drain();

    load_matrix(random_bank(1'b1));
    run_boxes(60);
    drain();
    load_matrix(random_bank(1'b1));
    run_boxes(60);
    drain();

    load_matrix(uniform_bank(coord_t'(hi)));
    run_boxes(50);
    drain();
    load_matrix(uniform_bank(coord_t'(lo)));
    run_boxes(50);
    drain();
    load_matrix(uniform_bank('0));
    run_boxes(40);
    drain();

    load_matrix(random_bank(1'b0));
    run_boxes(50);
    drain();
    load_matrix(random_bank(1'b0));
    run_boxes(50);
    drain();

    // back to identity, both sides at full rate
    bank = uniform_bank('0);
    bank[0] = {32'd0, coord_t'(Q)};
    bank[2] = {coord_t'(Q), 32'd0};
    bank[5] = {32'd0, coord_t'(Q)};
    bank[7] = {coord_t'(Q), 32'd0};
    load_matrix(bank);
    no_idle = 1'b1;
    run_boxes(80);
    drain();
    repeat (LATENCY + 4) @(posedge clk);

    sb.check_drained();
    $display("Sent %0d boxes under %0d matrix settings; %0d results checked, %0d culled.",
             boxes_sent, settings_used, sb.checked, sb.culled_count);
    $display("Covered all six planes, exact boundaries, swapped bounds, extreme matrices.");
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
